/* design/lc3bx_pkg.sv */
package lc3bx_pkg;

	localparam int NUM_REGS = 8;
	localparam int RW       = $clog2(NUM_REGS);

	localparam logic [2:0] CC_RESET = 3'b010;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_EXEC  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LDB  = 4'd2;
	localparam logic [3:0] OP_STB  = 4'd3;
	localparam logic [3:0] OP_JSR  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDW  = 4'd6;
	localparam logic [3:0] OP_STW  = 4'd7;
	localparam logic [3:0] OP_XOR  = 4'd9;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_SHF  = 4'd13;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_FETCH,
		ST_EXEC,
		ST_MEM
	} state_t;

	typedef struct packed {
		logic          illegal_opcode;
		logic          halted;
		logic          mem_written;
		logic [15:0]   reg_value;
		logic [RW-1:0] reg_index;
		logic          reg_written;
		logic [15:0]   read_data;
		logic [2:0]    cond_nzp;
		logic [15:0]   pc_out;
	} result_t;

	function automatic logic [2:0] nzp(input logic [15:0] v);
		logic [2:0] r;
		if (v == 16'd0) begin
			r = 3'b010;
		end else if (v[15]) begin
			r = 3'b100;
		end else begin
			r = 3'b001;
		end
		return r;
	endfunction

endpackage

/* design/lc3b_instruction_executor_unit.sv */
// LC-3b executor with an internal word memory and eight registers. Each transaction on
// s_* is a memory write, a memory read or one executed instruction (ALU, branch, jump,
// LEA and STW go through fetch and execute; LDB, STB, LDW and TRAP add a memory step),
// and returns exactly one result transaction on m_*. The memory has one read port and
// one write port; the instruction fetch and the data access share the read port.
// After reset the memory is zeroed one word a cycle: s_tready stays low until
// every word is cleared. A new request is taken while a result is being handed off.
module lc3b_instruction_executor_unit #(
	parameter int MEM_WORDS = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // address[15:0], write_data[31:16]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// pc_out[15:0], cond_nzp[18:16], read_data[34:19], reg_written[35],
	// reg_index[38:36], reg_value[54:39], mem_written[55], halted[56],
	// illegal_opcode[57], zero[63:58]
	output logic [63:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam int RW = lc3bx_pkg::RW;
	localparam int QSTEPS = 7;
	localparam int WW = 16 + QSTEPS;

	function automatic logic [AW-1:0] widx(input logic [15:0] byte_addr);
		logic [WW-1:0] w;
		w = {{(WW-15){1'b0}}, byte_addr[15:1]};
		for (int k = QSTEPS - 1; k >= 0; k--) begin
			if (w >= (WW'(MEM_WORDS) << k)) begin
				w = w - (WW'(MEM_WORDS) << k);
			end
		end
		return w[AW-1:0];
	endfunction

	lc3bx_pkg::state_t state_q, state_d;

	logic [AW-1:0] clr_q;
	logic [15:0]   start_pc_q;
	logic [15:0]   pc_q, pc_d;
	logic [2:0]    cc_q, cc_d;
	logic          started_q, started_d;
	logic          stopped_q, stopped_d;

	logic [15:0]   mem [MEM_WORDS];
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [15:0]   mem_wd;
	logic [15:0]   mem_rdata_q;

	logic [15:0]   rf_mem [lc3bx_pkg::NUM_REGS];
	logic [lc3bx_pkg::NUM_REGS-1:0] rf_vld_q;
	logic          rf_we;
	logic [RW-1:0] rf_wa, rf_ra, rf_rb;
	logic [15:0]   rf_wd;
	logic [15:0]   rf_a_q, rf_b_q;
	logic          a_vld_q, b_vld_q;
	logic [15:0]   a, b;

	logic [15:0]   ir_q;
	logic [15:0]   ea_q, ea_d;
	logic [3:0]    op, op_f;

	logic          acc;
	logic [1:0]    req_type;
	logic [15:0]   addr_in, wdata_in, pc_e;
	logic          go_fetch, op_mem;

	logic          done;
	lc3bx_pkg::result_t res, res_q;
	logic          m_tvalid_q;

	logic          fin, wr, setcc;
	logic [15:0]   val, npc, ea_b, ea_w, w, off9;
	logic [RW-1:0] widx_r;

	assign cfg_ready = 1'b1;
	assign req_type  = s_tuser;
	assign addr_in   = s_tdata[15:0];
	assign wdata_in  = s_tdata[31:16];
	assign s_tready  = (state_q == lc3bx_pkg::ST_IDLE) && (!m_tvalid_q || m_tready);
	assign acc       = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {6'd0, res_q};

	assign pc_e     = started_q ? pc_q : start_pc_q;
	assign go_fetch = !stopped_q && (pc_e != 16'd0);
	assign op       = ir_q[15:12];
	assign op_f     = mem_rdata_q[15:12];
	assign op_mem   = (op == lc3bx_pkg::OP_LDB) || (op == lc3bx_pkg::OP_STB) ||
	                  (op == lc3bx_pkg::OP_LDW) || (op == lc3bx_pkg::OP_TRAP);

	assign a = a_vld_q ? rf_a_q : 16'd0;
	assign b = b_vld_q ? rf_b_q : 16'd0;

	assign rf_ra = mem_rdata_q[8:6];
	assign rf_rb = ((op_f == lc3bx_pkg::OP_STB) || (op_f == lc3bx_pkg::OP_STW)) ?
	               mem_rdata_q[11:9] : mem_rdata_q[2:0];

	assign off9 = {{6{ir_q[8]}}, ir_q[8:0], 1'b0};
	assign ea_b = a + {{10{ir_q[5]}}, ir_q[5:0]};
	assign ea_w = a + {{9{ir_q[5]}}, ir_q[5:0], 1'b0};
	assign w    = mem_rdata_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lc3bx_pkg::ST_CLEAR: begin
				if (clr_q == AW'(MEM_WORDS - 1)) state_d = lc3bx_pkg::ST_IDLE;
			end
			lc3bx_pkg::ST_IDLE: begin
				if (acc) begin
					if (req_type == lc3bx_pkg::REQ_READ) begin
						state_d = lc3bx_pkg::ST_READ;
					end else if (req_type == lc3bx_pkg::REQ_EXEC && go_fetch) begin
						state_d = lc3bx_pkg::ST_FETCH;
					end
				end
			end
			lc3bx_pkg::ST_READ:  state_d = lc3bx_pkg::ST_IDLE;
			lc3bx_pkg::ST_FETCH: state_d = lc3bx_pkg::ST_EXEC;
			lc3bx_pkg::ST_EXEC:  state_d = op_mem ? lc3bx_pkg::ST_MEM : lc3bx_pkg::ST_IDLE;
			lc3bx_pkg::ST_MEM:   state_d = lc3bx_pkg::ST_IDLE;
			default:             state_d = lc3bx_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		done      = 1'b0;
		res       = '0;
		pc_d      = pc_q;
		cc_d      = cc_q;
		stopped_d = stopped_q;
		started_d = started_q;
		mem_we    = 1'b0;
		mem_wa    = widx(addr_in);
		mem_wd    = wdata_in;
		mem_ra    = widx(addr_in);
		ea_d      = ea_q;
		fin       = 1'b0;
		wr        = 1'b0;
		setcc     = 1'b0;
		val       = 16'd0;
		widx_r    = ir_q[11:9];
		npc       = pc_q + 16'd2;
		case (state_q)
			lc3bx_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = 16'd0;
			end
			lc3bx_pkg::ST_IDLE: begin
				if (req_type != lc3bx_pkg::REQ_READ) mem_ra = widx(pc_e);
				if (acc) begin
					case (req_type)
						lc3bx_pkg::REQ_WRITE: begin
							mem_we = 1'b1;
							done   = 1'b1;
						end
						lc3bx_pkg::REQ_READ: ;
						lc3bx_pkg::REQ_EXEC: begin
							if (stopped_q) begin
								done = 1'b1;
							end else begin
								started_d = 1'b1;
								pc_d      = pc_e;
								if (pc_e == 16'd0) begin
									stopped_d = 1'b1;
									done      = 1'b1;
								end
							end
						end
						default: done = 1'b1;
					endcase
				end
			end
			lc3bx_pkg::ST_READ: begin
				done           = 1'b1;
				res.read_data  = mem_rdata_q;
			end
			lc3bx_pkg::ST_FETCH: ;
			lc3bx_pkg::ST_EXEC: begin
				fin = 1'b1;
				case (op)
					lc3bx_pkg::OP_BR: begin
						if (|(ir_q[11:9] & cc_q)) npc = npc + off9;
					end
					lc3bx_pkg::OP_ADD, lc3bx_pkg::OP_AND, lc3bx_pkg::OP_XOR: begin
						val = ir_q[5] ? {{11{ir_q[4]}}, ir_q[4:0]} : b;
						if (op == lc3bx_pkg::OP_ADD) begin
							val = a + val;
						end else if (op == lc3bx_pkg::OP_AND) begin
							val = a & val;
						end else begin
							val = a ^ val;
						end
						wr    = 1'b1;
						setcc = 1'b1;
					end
					lc3bx_pkg::OP_LDB, lc3bx_pkg::OP_STB: begin
						fin    = 1'b0;
						ea_d   = ea_b;
						mem_ra = widx(ea_b);
					end
					lc3bx_pkg::OP_LDW: begin
						fin    = 1'b0;
						ea_d   = ea_w;
						mem_ra = widx(ea_w);
					end
					lc3bx_pkg::OP_TRAP: begin
						fin    = 1'b0;
						mem_ra = widx({7'd0, ir_q[7:0], 1'b0});
					end
					lc3bx_pkg::OP_STW: begin
						mem_we          = 1'b1;
						mem_wa          = widx(ea_w);
						mem_wd          = b;
						res.mem_written = 1'b1;
					end
					lc3bx_pkg::OP_JSR: begin
						val    = npc;
						npc    = ir_q[11] ? npc + {{4{ir_q[10]}}, ir_q[10:0], 1'b0} : a;
						wr     = 1'b1;
						widx_r = RW'(7);
					end
					lc3bx_pkg::OP_JMP: npc = a;
					lc3bx_pkg::OP_SHF: begin
						if (!ir_q[4]) begin
							val = a << ir_q[3:0];
						end else if (!ir_q[5]) begin
							val = a >> ir_q[3:0];
						end else begin
							val = 16'($signed(a) >>> ir_q[3:0]);
						end
						wr    = 1'b1;
						setcc = 1'b1;
					end
					lc3bx_pkg::OP_LEA: begin
						val = npc + off9;
						wr  = 1'b1;
					end
					default: begin
						npc                = pc_q;
						stopped_d          = 1'b1;
						res.illegal_opcode = 1'b1;
					end
				endcase
			end
			lc3bx_pkg::ST_MEM: begin
				fin = 1'b1;
				case (op)
					lc3bx_pkg::OP_LDB: begin
						val   = ea_q[0] ? {{8{w[15]}}, w[15:8]} : {{8{w[7]}}, w[7:0]};
						wr    = 1'b1;
						setcc = 1'b1;
					end
					lc3bx_pkg::OP_STB: begin
						mem_we          = 1'b1;
						mem_wa          = widx(ea_q);
						mem_wd          = ea_q[0] ? {b[7:0], w[7:0]} : {w[15:8], b[7:0]};
						res.mem_written = 1'b1;
					end
					lc3bx_pkg::OP_LDW: begin
						val   = w;
						wr    = 1'b1;
						setcc = 1'b1;
					end
					default: begin
						val    = npc;
						npc    = w;
						wr     = 1'b1;
						widx_r = RW'(7);
					end
				endcase
			end
			default: ;
		endcase

		rf_we = fin && wr;
		rf_wa = widx_r;
		rf_wd = val;
		if (fin) begin
			done = 1'b1;
			pc_d = npc;
			if (setcc) cc_d = lc3bx_pkg::nzp(val);
			if (npc == 16'd0) stopped_d = 1'b1;
			if (wr) begin
				res.reg_written = 1'b1;
				res.reg_index   = widx_r;
				res.reg_value   = val;
			end
		end
		res.pc_out   = pc_d;
		res.cond_nzp = cc_d;
		res.halted   = stopped_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lc3bx_pkg::ST_CLEAR;
			clr_q      <= '0;
			start_pc_q <= 16'd0;
			pc_q       <= 16'd0;
			cc_q       <= lc3bx_pkg::CC_RESET;
			started_q  <= 1'b0;
			stopped_q  <= 1'b0;
			rf_vld_q   <= '0;
			a_vld_q    <= 1'b0;
			b_vld_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pc_q      <= pc_d;
			cc_q      <= cc_d;
			started_q <= started_d;
			stopped_q <= stopped_d;
			if (state_q == lc3bx_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg_valid && cfg_ready) start_pc_q <= cfg_data;
			if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
			if (state_q == lc3bx_pkg::ST_FETCH) begin
				a_vld_q <= rf_vld_q[rf_ra];
				b_vld_q <= rf_vld_q[rf_rb];
			end
			if (done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) res_q <= res;
		if (state_q == lc3bx_pkg::ST_FETCH) ir_q <= mem_rdata_q;
		ea_q <= ea_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_wa] <= rf_wd;
		if (state_q == lc3bx_pkg::ST_FETCH) begin
			rf_a_q <= rf_mem[rf_ra];
			rf_b_q <= rf_mem[rf_rb];
		end
	end

endmodule

/* design/lc3bx_checker.sv */
module lc3bx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [15:0] cfg_data
);

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no new request while a result is stuck
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while result stalled");

	a_illegal_halts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[57] |-> m_tdata[56] && !m_tdata[55] && !m_tdata[35])
		else $error("illegal opcode without halt or with side effects");

	a_no_write_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[35] |-> m_tdata[54:36] == 19'd0)
		else $error("register fields set without a register write");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tvalid |-> m_tready)
		else $error("request accepted with a result still pending");

endmodule

bind lc3b_instruction_executor_unit lc3bx_checker u_lc3bx_checker (.*);
